[rtl/palette_nearest_color_matcher_unit_defines.svh]
// assertion macros used by the palette matcher top level
`ifndef PALETTE_NEAREST_COLOR_MATCHER_UNIT_DEFINES_SVH
`define PALETTE_NEAREST_COLOR_MATCHER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PNCM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PNCM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pncm_pkg.sv]
// types, constants and codes of the palette nearest color matcher
package pncm_pkg;

    localparam int PAL_DEPTH      = 256;
    localparam int FIRST_SEARCHED = 4;
    localparam int LUT_SIZE       = 4096;
    localparam int PAL_AW         = 8;
    localparam int LUT_AW         = 12;
    localparam int IDX_W          = 8;
    localparam int LEN_W          = 9;
    localparam int COLOR_W        = 24;
    localparam int CH_W           = 8;
    localparam int SQ_W           = 16;
    localparam int PROD_W         = 27;
    localparam int DIST_W         = 29;

    localparam logic [1:0] FUNC_WRITE   = 2'd0;
    localparam logic [1:0] FUNC_REBUILD = 2'd1;
    localparam logic [1:0] FUNC_MATCH   = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic [IDX_W-1:0]   entry_index;
        logic [COLOR_W-1:0] entry_color;
        logic [COLOR_W-1:0] pixel_rgb;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] color_index;
        logic             rebuild_done;
        logic             table_ready;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_RB_CELL,
        ST_RB_SCAN,
        ST_RB_DRAIN,
        ST_RB_WRITE,
        ST_RB_DONE
    } t_state;

    typedef struct packed {
        logic pal_write;
        logic lut_read;
        logic rb_start;
        logic cell_start;
        logic issue;
        logic lut_write;
        logic cell_next;
        logic load_match;
        logic load_done;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic search_none;
        logic pidx_last;
        logic pipe_empty;
        logic cell_last;
    } t_status;

endpackage

[rtl/pncm_ctrl.sv]
// controller state machine: input acceptance, rebuild sequencing, result loading
module pncm_ctrl
    import pncm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_func,
    input  t_status    i_status,
    output logic       o_in_stall,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // input is open when idle or when a waiting result leaves this cycle
    always_comb begin
        case (r_state)
            ST_IDLE:              accept_en = 1'b1;
            ST_MATCH, ST_RB_DONE: accept_en = i_status.out_free;
            default:              accept_en = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:     n_state = ST_IDLE;
            ST_MATCH:    n_state = i_status.out_free ? ST_IDLE : ST_MATCH;
            ST_RB_CELL:  n_state = i_status.search_none ? ST_RB_WRITE : ST_RB_SCAN;
            ST_RB_SCAN:  n_state = i_status.pidx_last ? ST_RB_DRAIN : ST_RB_SCAN;
            ST_RB_DRAIN: n_state = i_status.pipe_empty ? ST_RB_WRITE : ST_RB_DRAIN;
            ST_RB_WRITE: n_state = i_status.cell_last ? ST_RB_DONE : ST_RB_CELL;
            ST_RB_DONE:  n_state = i_status.out_free ? ST_IDLE : ST_RB_DONE;
            default:     n_state = ST_IDLE;
        endcase
        if (accept_en && i_in_valid) begin
            case (i_func)
                FUNC_REBUILD: n_state = ST_RB_CELL;
                FUNC_MATCH:   n_state = ST_MATCH;
                default:      n_state = ST_IDLE;
            endcase
        end
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_stall = !accept_en;
        case (r_state)
            ST_MATCH:    o_cmd.load_match = i_status.out_free;
            ST_RB_CELL:  o_cmd.cell_start = 1'b1;
            ST_RB_SCAN:  o_cmd.issue      = 1'b1;
            ST_RB_WRITE: begin
                o_cmd.lut_write = 1'b1;
                o_cmd.cell_next = !i_status.cell_last;
            end
            ST_RB_DONE:  o_cmd.load_done  = i_status.out_free;
            default:     o_cmd            = '0;
        endcase
        if (accept_en && i_in_valid) begin
            case (i_func)
                FUNC_WRITE:   o_cmd.pal_write = 1'b1;
                FUNC_REBUILD: o_cmd.rb_start  = 1'b1;
                FUNC_MATCH:   o_cmd.lut_read  = 1'b1;
                default:      o_cmd.pal_write = 1'b0;
            endcase
        end
    end

endmodule

[rtl/pncm_dp.sv]
// datapath: palette and table memories, redmean distance pipeline, result register
module pncm_dp
    import pncm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_data,
    input  t_in_item         i_in_data,
    input  logic             i_out_stall,
    input  t_cmd             i_cmd,
    output t_status          o_status,
    output logic             o_out_valid,
    output t_out_item        o_out_data
);

    logic [COLOR_W-1:0] r_pal [PAL_DEPTH];
    logic [IDX_W-1:0]   r_lut [LUT_SIZE];
    logic [COLOR_W-1:0] r_pal_q;
    logic [IDX_W-1:0]   r_lut_q;

    logic [LEN_W-1:0]   r_len;
    logic [LUT_AW-1:0]  r_cell;
    logic [PAL_AW-1:0]  r_pidx;

    logic               r_rd_v;
    logic [PAL_AW-1:0]  r_rd_idx;
    logic               r_a_v;
    logic [PAL_AW-1:0]  r_a_idx;
    logic [SQ_W-1:0]    r_dr2;
    logic [SQ_W-1:0]    r_dg2;
    logic [SQ_W-1:0]    r_db2;
    logic [CH_W:0]      r_sr;
    logic               r_b_v;
    logic [PAL_AW-1:0]  r_b_idx;
    logic [DIST_W-1:0]  r_dist;
    logic               r_have;
    logic [DIST_W-1:0]  r_best;
    logic [IDX_W-1:0]   r_best_idx;
    logic               r_built;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [LEN_W-1:0]   len_eff;
    logic [LUT_AW-1:0]  pix_addr;
    logic [CH_W-1:0]    c_r;
    logic [CH_W-1:0]    c_g;
    logic [CH_W-1:0]    c_b;
    logic [CH_W-1:0]    p_r;
    logic [CH_W-1:0]    p_g;
    logic [CH_W-1:0]    p_b;
    logic [CH_W-1:0]    dr;
    logic [CH_W-1:0]    dg;
    logic [CH_W-1:0]    db;
    logic [10:0]        w_r;
    logic [10:0]        w_b;
    logic [PROD_W-1:0]  prod_r;
    logic [PROD_W-1:0]  prod_b;
    logic [DIST_W-1:0]  dist_sum;
    logic               out_free;

    assign len_eff  = (r_len > LEN_W'(PAL_DEPTH)) ? LEN_W'(PAL_DEPTH) : r_len;
    assign pix_addr = {i_in_data.pixel_rgb[23:20], i_in_data.pixel_rgb[15:12],
                       i_in_data.pixel_rgb[7:4]};
    assign out_free = !r_out_valid || !i_out_stall;

    // palette memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.pal_write && ({1'b0, i_in_data.entry_index} < LEN_W'(PAL_DEPTH))) begin
            r_pal[i_in_data.entry_index[PAL_AW-1:0]] <= i_in_data.entry_color;
        end
        if (i_cmd.issue) begin
            r_pal_q <= r_pal[r_pidx];
        end
    end

    // lookup table memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.lut_write) begin
            r_lut[r_cell] <= r_best_idx;
        end
        if (i_cmd.lut_read) begin
            r_lut_q <= r_lut[pix_addr];
        end
    end

    // stage a: channel differences and squares
    assign c_r = {r_cell[11:8], 4'h0};
    assign c_g = {r_cell[7:4], 4'h0};
    assign c_b = {r_cell[3:0], 4'h0};
    assign p_r = r_pal_q[23:16];
    assign p_g = r_pal_q[15:8];
    assign p_b = r_pal_q[7:0];
    assign dr  = (c_r > p_r) ? (c_r - p_r) : (p_r - c_r);
    assign dg  = (c_g > p_g) ? (c_g - p_g) : (p_g - c_g);
    assign db  = (c_b > p_b) ? (c_b - p_b) : (p_b - c_b);

    // stage b: weighted sum
    assign w_r      = 11'd1024 + {2'b00, r_sr};
    assign w_b      = 11'd1534 - {2'b00, r_sr};
    assign prod_r   = PROD_W'(w_r) * PROD_W'(r_dr2);
    assign prod_b   = PROD_W'(w_b) * PROD_W'(r_db2);
    assign dist_sum = DIST_W'(prod_r) + DIST_W'({r_dg2, 11'b0}) + DIST_W'(prod_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_rd_v      <= 1'b0;
            r_a_v       <= 1'b0;
            r_b_v       <= 1'b0;
            r_built     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len <= i_cfg_data;
            end
            r_rd_v <= i_cmd.issue;
            r_a_v  <= r_rd_v;
            r_b_v  <= r_a_v;
            if (i_cmd.load_done) begin
                r_built <= 1'b1;
            end
            if (i_cmd.load_match || i_cmd.load_done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rb_start) begin
            r_cell <= '0;
        end else if (i_cmd.cell_next) begin
            r_cell <= r_cell + LUT_AW'(1);
        end

        if (i_cmd.cell_start) begin
            r_pidx <= PAL_AW'(FIRST_SEARCHED);
        end else if (i_cmd.issue) begin
            r_pidx <= r_pidx + PAL_AW'(1);
        end

        r_rd_idx <= r_pidx;
        r_a_idx  <= r_rd_idx;
        r_dr2    <= SQ_W'(dr) * SQ_W'(dr);
        r_dg2    <= SQ_W'(dg) * SQ_W'(dg);
        r_db2    <= SQ_W'(db) * SQ_W'(db);
        r_sr     <= {1'b0, c_r} + {1'b0, p_r};
        r_b_idx  <= r_a_idx;
        r_dist   <= dist_sum;

        // running minimum, lowest index kept on ties
        if (i_cmd.cell_start) begin
            r_have     <= 1'b0;
            r_best     <= '0;
            r_best_idx <= '0;
        end else if (r_b_v && (!r_have || (r_dist < r_best))) begin
            r_have     <= 1'b1;
            r_best     <= r_dist;
            r_best_idx <= r_b_idx;
        end

        if (i_cmd.load_match) begin
            r_out.color_index  <= r_built ? r_lut_q : IDX_W'(0);
            r_out.rebuild_done <= 1'b0;
            r_out.table_ready  <= r_built;
        end else if (i_cmd.load_done) begin
            r_out.color_index  <= IDX_W'(0);
            r_out.rebuild_done <= 1'b1;
            r_out.table_ready  <= 1'b1;
        end
    end

    assign o_status.out_free    = out_free;
    assign o_status.search_none = (len_eff <= LEN_W'(FIRST_SEARCHED));
    assign o_status.pidx_last   = ({1'b0, r_pidx} == (len_eff - LEN_W'(1)));
    assign o_status.pipe_empty  = !r_rd_v && !r_a_v && !r_b_v;
    assign o_status.cell_last   = (r_cell == LUT_AW'(LUT_SIZE - 1));

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[rtl/palette_nearest_color_matcher_unit.sv]
// top level of the redmean palette matcher with a 12-bit lookup table
//
//  channel   | signals                              | direction
//  ----------+--------------------------------------+----------
//  in        | i_in_valid, o_in_stall, i_in_data    | item in
//  out       | o_out_valid, i_out_stall, o_out_data | result out
//  cfg       | i_cfg_we, i_cfg_data                 | palette_length write
//
// match: table read then result register; with the output not stalled a match beat is
// taken every cycle. rebuild: 4096 table cells, each searching its entries through the
// single palette read port feeding the 3-stage distance pipeline; a cell with no searched
// entries is written directly.
// reset is synchronous; memories are not cleared, a match before a rebuild gives 0.
// a stalled result holds; a match or rebuild waiting on it takes no new beat before the cycle the result leaves.
`include "palette_nearest_color_matcher_unit_defines.svh"

module palette_nearest_color_matcher_unit
    import pncm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data
);

    t_cmd    cmd;
    t_status status;
    logic    done_beat;
    logic    done_fields_ok;
    logic    ready_beat;
    logic    unready_beat;

    pncm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_in_data.func),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    pncm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    assign done_beat      = o_out_valid && o_out_data.rebuild_done;
    assign done_fields_ok = (o_out_data.color_index == '0) && o_out_data.table_ready;
    assign ready_beat     = o_out_valid && o_out_data.table_ready;
    assign unready_beat   = o_out_valid && !o_out_data.table_ready;

    // no input beat is taken while the distance pipeline is being fed
    `PNCM_ASSERT_NOW(a_scan_blocks_input, i_clk, i_rst_n, cmd.issue, o_in_stall, "scan open")

    // a rebuild result carries index zero and a ready table
    `PNCM_ASSERT_NOW(a_done_format, i_clk, i_rst_n, done_beat, done_fields_ok, "bad rebuild")

    // once a table is reported ready it stays ready
    `PNCM_ASSERT_NEXT(a_ready_sticky, i_clk, i_rst_n, ready_beat, !unready_beat, "ready fell")

endmodule

[sim/palette_nearest_color_matcher_unit_test.sv]
`timescale 1ns / 1ps
// self-checking testbench of the palette matcher against a redmean table predictor
module palette_nearest_color_matcher_unit_test;
    import pncm_pkg::*;

    localparam logic [1:0] FUNC_UNUSED   = 2'd3;
    localparam int         SETTLE_CYCLES = 16;
    // nothing is accepted for the whole of one full-length rebuild
    localparam int         QUIET_LIMIT   = 4_500_000;
    localparam int         MAX_PRINTED   = 100;

    class palette_scoreboard;
        logic [COLOR_W-1:0] palette [PAL_DEPTH];
        logic [IDX_W-1:0]   lut [LUT_SIZE];
        bit                 built;
        logic [LEN_W-1:0]   pal_len;
        t_out_item          pending_q [$];
        int                 errors;

        function new();
            built   = 1'b0;
            pal_len = '0;
            errors  = 0;
        endfunction

        function int unsigned redmean_dist(int unsigned r1, int unsigned g1, int unsigned b1,
                                           logic [COLOR_W-1:0] c);
            int unsigned r2, g2, b2, sr, dr, dg, db;
            r2 = 32'(c[23:16]);
            g2 = 32'(c[15:8]);
            b2 = 32'(c[7:0]);
            sr = r1 + r2;
            dr = (r1 > r2) ? r1 - r2 : r2 - r1;
            dg = (g1 > g2) ? g1 - g2 : g2 - g1;
            db = (b1 > b2) ? b1 - b2 : b2 - b1;
            return (1024 + sr) * dr * dr + 2048 * dg * dg + (1534 - sr) * db * db;
        endfunction

        function void rebuild_lut();
            int unsigned      span, best, d, r, g, b;
            int               a, e;
            logic [IDX_W-1:0] best_idx;
            bit               have;
            span = (pal_len > PAL_DEPTH) ? PAL_DEPTH : pal_len;
            for (a = 0; a < LUT_SIZE; a++) begin
                r = ((a >> 8) & 15) << 4;
                g = ((a >> 4) & 15) << 4;
                b = (a & 15) << 4;
                best_idx = '0;
                best     = 0;
                have     = 1'b0;
                // strict less-than keeps the lowest index on a tie
                for (e = FIRST_SEARCHED; e < span; e++) begin
                    d = redmean_dist(r, g, b, palette[e]);
                    if (!have || d < best) begin
                        best     = d;
                        best_idx = IDX_W'(e);
                        have     = 1'b1;
                    end
                end
                lut[a] = best_idx;
            end
        endfunction

        function void note_item(t_in_item it);
            t_out_item         res;
            logic [LUT_AW-1:0] addr;
            case (it.func)
                FUNC_WRITE: palette[it.entry_index] = it.entry_color;
                FUNC_REBUILD: begin
                    rebuild_lut();
                    built            = 1'b1;
                    res.color_index  = '0;
                    res.rebuild_done = 1'b1;
                    res.table_ready  = 1'b1;
                    pending_q.push_back(res);
                end
                FUNC_MATCH: begin
                    addr = {it.pixel_rgb[23:20], it.pixel_rgb[15:12], it.pixel_rgb[7:4]};
                    res.color_index  = built ? lut[addr] : '0;
                    res.rebuild_done = 1'b0;
                    res.table_ready  = built;
                    pending_q.push_back(res);
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= MAX_PRINTED) $display("mismatch at %0t: %s", $time, what);
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (pending_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat: idx %0d done %b ready %b",
                                          got.color_index, got.rebuild_done, got.table_ready));
            end else begin
                want = pending_q.pop_front();
                if (got.color_index !== want.color_index)
                    report_mismatch($sformatf("color_index %0d, want %0d",
                                              got.color_index, want.color_index));
                if (got.rebuild_done !== want.rebuild_done)
                    report_mismatch($sformatf("rebuild_done %b, want %b",
                                              got.rebuild_done, want.rebuild_done));
                if (got.table_ready !== want.table_ready)
                    report_mismatch($sformatf("table_ready %b, want %b",
                                              got.table_ready, want.table_ready));
            end
        endtask
    endclass

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [LEN_W-1:0] cfg_data  = '0;
    logic             in_valid  = 1'b0;
    t_in_item         in_data   = '0;
    logic             out_stall = 1'b0;
    logic             in_stall;
    logic             out_valid;
    t_out_item        out_data;

    palette_scoreboard sb;
    bit                written [PAL_DEPTH];
    int                cur_len      = 0;
    bit                in_burst     = 1'b0;
    int                stall_mode   = 0;
    int                stall_left   = 0;
    int                quiet_cycles = 0;

    palette_nearest_color_matcher_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver back-pressure: quiet stretches, light or heavy random stall, long holds
    always @(posedge clk) begin
        int r;
        r = $urandom_range(999);
        if (r < 5) stall_mode = $urandom_range(0, 2);
        if (!rst_n || stall_mode == 0) begin
            out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end else if (r < 15) begin
            stall_left = $urandom_range(5, 40);
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < (stall_mode == 1 ? 15 : 50));
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) sb.note_item(in_data);
            if (out_valid && !out_stall) sb.check_result(out_data);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("palette_nearest_color_matcher_unit verification failed");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (in_burst || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    // valid stays high across back-to-back beats; it drops for a gap or while results drain
    task automatic send_item(t_in_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
    endtask

    function automatic t_in_item random_item(logic [1:0] f);
        t_in_item it;
        it.func        = f;
        it.entry_index = IDX_W'($urandom);
        it.entry_color = COLOR_W'($urandom);
        it.pixel_rgb   = COLOR_W'($urandom);
        return it;
    endfunction

    task automatic put_write(int idx, logic [COLOR_W-1:0] color);
        t_in_item it;
        it             = random_item(FUNC_WRITE);
        it.entry_index = IDX_W'(idx);
        it.entry_color = color;
        written[idx]   = 1'b1;
        send_item(it);
    endtask

    task automatic put_match(logic [COLOR_W-1:0] px);
        t_in_item it;
        it           = random_item(FUNC_MATCH);
        it.pixel_rgb = px;
        send_item(it);
    endtask

    task automatic put_plain(logic [1:0] f);
        send_item(random_item(f));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0) @(posedge clk);
        // a palette write leaves nothing to wait for, give it time to land
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(int len);
        cfg_we   <= 1'b1;
        cfg_data <= LEN_W'(len);
        @(posedge clk);
        sb.pal_len = LEN_W'(len);
        cur_len    = len;
        cfg_we   <= 1'b0;
    endtask

    function automatic int searched_end();
        return (cur_len > PAL_DEPTH) ? PAL_DEPTH : cur_len;
    endfunction

    // a rebuild must never read a palette entry that was never written
    function automatic bit can_rebuild();
        for (int i = FIRST_SEARCHED; i < searched_end(); i++)
            if (!written[i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [COLOR_W-1:0] pick_color();
        int r, j;
        r = $urandom_range(99);
        j = $urandom_range(FIRST_SEARCHED, PAL_DEPTH - 1);
        // copy of an existing entry gives equal distances
        if (r < 20 && written[j]) return sb.palette[j];
        if (r < 30) return $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
        return COLOR_W'($urandom);
    endfunction

    task automatic run_phase(int len, int n_items);
        int span, r;
        drain_results();
        write_length(len);
        span     = searched_end();
        in_burst = ($urandom_range(3) == 0);
        // for a short or oversized length, fill the searched entries, then build the table
        if (span <= 12 || len > PAL_DEPTH) begin
            for (int i = FIRST_SEARCHED; i < span; i++)
                if (!written[i] || $urandom_range(1)) put_write(i, pick_color());
            put_plain(FUNC_REBUILD);
        end
        for (int k = 0; k < n_items; k++) begin
            r = $urandom_range(99);
            if (r == 0) in_burst = !in_burst;
            if (r < 65)
                put_match(COLOR_W'($urandom));
            else if (r < 83)
                put_write($urandom_range(PAL_DEPTH - 1), pick_color());
            else if (r < 88)
                put_plain(FUNC_UNUSED);
            else if (r < 89 && span <= 12 && can_rebuild())
                put_plain(FUNC_REBUILD);
            else if (r < 91)
                drain_results();
            else
                put_match(COLOR_W'($urandom));
        end
    endtask

    initial begin
        int len;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        write_length(0);

        // match before any rebuild, unused code, rebuild with nothing searched
        put_match(24'h000000);
        put_match(24'hFFFFFF);
        put_plain(FUNC_UNUSED);
        put_plain(FUNC_REBUILD);
        put_match(24'h0F0F0F);
        put_write(0, 24'hFFFFFF);
        put_write(4, 24'h000000);
        put_write(5, 24'hFFFFFF);
        put_write(6, 24'hFF0000);
        put_write(7, 24'h00FF00);
        put_write(8, 24'h0000FF);
        put_write(9, 24'h808080);
        put_write(10, 24'h000000);
        put_write(255, COLOR_W'($urandom));
        // palette changed, table keeps its old contents
        put_match(24'hFFFFFF);

        // length at the first searched entry still searches nothing
        drain_results();
        write_length(FIRST_SEARCHED);
        put_plain(FUNC_REBUILD);
        put_match(24'hFFFFFF);

        // black twice in the palette, lower entry wins
        drain_results();
        write_length(11);
        put_plain(FUNC_REBUILD);
        put_match(24'hFFFFFF);
        put_match(24'h000000);
        put_match(24'hF01010);
        put_match(24'h808080);

        for (int p = 0; p < 8; p++) begin
            if ($urandom_range(99) < 15)
                len = $urandom_range(0, FIRST_SEARCHED);
            else
                len = $urandom_range(FIRST_SEARCHED + 1, 10);
            run_phase(len, $urandom_range(40, 70));
        end
        run_phase(PAL_DEPTH, 40);
        // oversized length acts as the full palette, the one long rebuild
        run_phase(2 ** LEN_W - 1, 40);
        drain_results();

        if (sb.errors == 0)
            $display("palette_nearest_color_matcher_unit verification clean");
        else
            $display("palette_nearest_color_matcher_unit verification failed");
        $finish;
    end

endmodule
